[rtl/tssu_pkg.sv]
// Package with the request and span types, pipeline types and the edge setup function.
`default_nettype none
package tssu_pkg;
  localparam int COORD_BITS = 12;
  localparam int DY_W = COORD_BITS + 1;
  localparam int NUM_W = 2 * COORD_BITS + 1;
  localparam int COLOUR_BITS = 24;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] third_x;
    logic signed [COORD_BITS-1:0] third_y;
    logic signed [COORD_BITS-1:0] row_y;
    logic [COLOUR_BITS-1:0] fill_colour;
  } req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] span_row;
    logic covered;
    logic signed [COORD_BITS-1:0] span_start;
    logic signed [COORD_BITS-1:0] span_end;
    logic [COLOUR_BITS-1:0] span_colour;
  } span_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic neg;
    logic flat;
    logic signed [COORD_BITS-1:0] xa;
    logic [COORD_BITS-1:0] dxm;
    logic [DY_W-1:0] t;
    logic [DY_W-1:0] dy;
    logic [NUM_W-1:0] rem;
    logic [COORD_BITS-1:0] quo;
  } edge_t;

  typedef struct packed {
    edge_t short_e;
    edge_t long_e;
    logic covered;
    logic signed [COORD_BITS-1:0] row;
    logic [COLOUR_BITS-1:0] colour;
  } work_t;

  function automatic edge_t make_edge(vtx_t a, vtx_t b, logic signed [COORD_BITS-1:0] row);
    edge_t e;
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dyv;
    logic signed [COORD_BITS:0] tv;
    dx = {b.x[COORD_BITS-1], b.x} - {a.x[COORD_BITS-1], a.x};
    dyv = {b.y[COORD_BITS-1], b.y} - {a.y[COORD_BITS-1], a.y};
    tv = {row[COORD_BITS-1], row} - {a.y[COORD_BITS-1], a.y};
    e = '0;
    e.neg = dx[COORD_BITS];
    e.flat = (dyv == '0);
    e.xa = a.x;
    e.dxm = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    e.t = tv;
    e.dy = dyv;
    return e;
  endfunction
endpackage
`default_nettype wire

[rtl/tssu_setup.sv]
// Setup stage: stable vertex sort by y, coverage test and edge selection.
`default_nettype none
module tssu_setup (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           valid_in,
  input  wire tssu_pkg::req_t req,
  output logic                valid,
  output tssu_pkg::work_t     work
);
  tssu_pkg::vtx_t a0, b0, a1, c1, t2, m2;
  tssu_pkg::vtx_t top_v, mid_v, bot_v;
  tssu_pkg::work_t work_next;
  logic above;

  always_comb begin
    a0 = '{x: req.first_x, y: req.first_y};
    b0 = '{x: req.second_x, y: req.second_y};
    c1 = '{x: req.third_x, y: req.third_y};
    if (a0.y > b0.y) begin
      a1 = b0;
      b0 = a0;
    end else begin
      a1 = a0;
    end
    if (b0.y > c1.y) begin
      bot_v = b0;
      m2 = c1;
    end else begin
      bot_v = c1;
      m2 = b0;
    end
    if (a1.y > m2.y) begin
      top_v = m2;
      t2 = a1;
    end else begin
      top_v = a1;
      t2 = m2;
    end
    mid_v = t2;
    above = req.row_y < mid_v.y;
    work_next.short_e = above ? tssu_pkg::make_edge(top_v, mid_v, req.row_y)
                              : tssu_pkg::make_edge(mid_v, bot_v, req.row_y);
    work_next.long_e = tssu_pkg::make_edge(top_v, bot_v, req.row_y);
    work_next.covered = (req.row_y >= top_v.y) && (req.row_y <= bot_v.y);
    work_next.row = req.row_y;
    work_next.colour = req.fill_colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      work <= work_next;
    end
  end
endmodule
`default_nettype wire

[rtl/tssu_mul.sv]
// Multiply stage: edge x distance times row offset for both edges.
`default_nettype none
module tssu_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            valid_in,
  input  wire tssu_pkg::work_t work_in,
  output logic                 valid,
  output tssu_pkg::work_t      work
);
  tssu_pkg::work_t work_next;

  always_comb begin
    work_next = work_in;
    work_next.short_e.rem = tssu_pkg::NUM_W'(work_in.short_e.dxm * work_in.short_e.t);
    work_next.long_e.rem = tssu_pkg::NUM_W'(work_in.long_e.dxm * work_in.long_e.t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      work <= work_next;
    end
  end
endmodule
`default_nettype wire

[rtl/tssu_div_stage.sv]
// One restoring division step that settles one quotient bit of both edges.
`default_nettype none
module tssu_div_stage #(
  parameter int BIT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            valid_in,
  input  wire tssu_pkg::work_t work_in,
  output logic                 valid,
  output tssu_pkg::work_t      work
);
  tssu_pkg::work_t work_next;
  logic [tssu_pkg::NUM_W-1:0] ds, dl;

  always_comb begin
    work_next = work_in;
    ds = tssu_pkg::NUM_W'(work_in.short_e.dy) << BIT;
    dl = tssu_pkg::NUM_W'(work_in.long_e.dy) << BIT;
    work_next.short_e.quo[BIT] = work_in.short_e.rem >= ds;
    if (work_in.short_e.rem >= ds) begin
      work_next.short_e.rem = work_in.short_e.rem - ds;
    end
    work_next.long_e.quo[BIT] = work_in.long_e.rem >= dl;
    if (work_in.long_e.rem >= dl) begin
      work_next.long_e.rem = work_in.long_e.rem - dl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      work <= work_next;
    end
  end
endmodule
`default_nettype wire

[rtl/tssu_finish.sv]
// Finish stage: edge x from quotient, span ordering and the output register.
`default_nettype none
module tssu_finish (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            valid_in,
  input  wire tssu_pkg::work_t work_in,
  output logic                 valid,
  output tssu_pkg::span_t      span
);
  localparam int CB = tssu_pkg::COORD_BITS;
  logic signed [CB-1:0] xs, xl;
  tssu_pkg::span_t span_next;

  function automatic logic signed [CB-1:0] edge_x(tssu_pkg::edge_t e);
    logic signed [CB:0] q;
    logic signed [CB:0] s;
    q = e.neg ? -$signed({1'b0, e.quo}) : $signed({1'b0, e.quo});
    s = $signed({e.xa[CB-1], e.xa}) + q;
    return e.flat ? e.xa : s[CB-1:0];
  endfunction

  always_comb begin
    xs = edge_x(work_in.short_e);
    xl = edge_x(work_in.long_e);
    span_next.span_row = work_in.row;
    span_next.covered = work_in.covered;
    span_next.span_colour = work_in.colour;
    if (!work_in.covered) begin
      span_next.span_start = '0;
      span_next.span_end = '0;
    end else if (xs > xl) begin
      span_next.span_start = xl;
      span_next.span_end = xs;
    end else begin
      span_next.span_start = xs;
      span_next.span_end = xl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      span <= span_next;
    end
  end
endmodule
`default_nettype wire

[rtl/triangle_scanline_span_unit.sv]
// Top level of the triangle scanline span unit.
// A request carries three vertices, a row and a fill colour on req with
// req_valid and req_ready. One span leaves on span with span_valid and
// span_ready for every request, in request order.
// The pipeline has a setup stage, a multiply stage, one restoring division
// stage per quotient bit (COORD_BITS of them) and a finish stage that holds
// the output register.
// Throughput is one request per cycle while span_ready is high.
// When the receiver stalls, every stage holds and req_ready drops as soon as
// the output register holds an untaken span; nothing is lost or repeated.
// A synchronous reset clears all valid bits, so the pipeline comes up empty
// and ready.
`default_nettype none
module triangle_scanline_span_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire tssu_pkg::req_t  req,
  output logic                 span_valid,
  input  wire logic            span_ready,
  output tssu_pkg::span_t      span
);
  localparam int CB = tssu_pkg::COORD_BITS;
  logic en;
  logic v_stg [0:CB+1];
  tssu_pkg::work_t w_stg [0:CB+1];

  assign en = !span_valid || span_ready;
  assign req_ready = en;

  tssu_setup u_setup (
    .clk(clk), .rst(rst), .en(en), .valid_in(req_valid), .req(req),
    .valid(v_stg[0]), .work(w_stg[0])
  );

  tssu_mul u_mul (
    .clk(clk), .rst(rst), .en(en), .valid_in(v_stg[0]), .work_in(w_stg[0]),
    .valid(v_stg[1]), .work(w_stg[1])
  );

  for (genvar k = 0; k < CB; k++) begin : g_div
    tssu_div_stage #(.BIT(CB - 1 - k)) u_div (
      .clk(clk), .rst(rst), .en(en), .valid_in(v_stg[k+1]), .work_in(w_stg[k+1]),
      .valid(v_stg[k+2]), .work(w_stg[k+2])
    );
  end

  tssu_finish u_finish (
    .clk(clk), .rst(rst), .en(en), .valid_in(v_stg[CB+1]), .work_in(w_stg[CB+1]),
    .valid(span_valid), .span(span)
  );
endmodule
`default_nettype wire

[tb/tb_triangle_scanline_span_unit.sv]
// Testbench for the triangle scanline span unit: random and directed requests, queued span check.
`timescale 1ns / 1ps
module tb_triangle_scanline_span_unit;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  tssu_pkg::req_t req;
  logic span_valid;
  logic span_ready;
  tssu_pkg::span_t span;

  triangle_scanline_span_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .span_valid(span_valid), .span_ready(span_ready), .span(span)
  );

  tssu_pkg::req_t pending_reqs[$];
  tssu_pkg::span_t expected_spans[$];
  int errors;
  int spans_seen;
  int covered_seen;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;
  bit send_pause;
  bit stim_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("tb_triangle_scanline_span_unit: done, errors");
    $finish;
  end

  function automatic longint edge_at(longint xa, longint ya, longint xb, longint yb,
                                     longint y);
    if (ya == yb) return xa;
    return xa + ((xb - xa) * (y - ya)) / (yb - ya);
  endfunction

  function automatic tssu_pkg::span_t predict_span(tssu_pkg::req_t r);
    tssu_pkg::span_t s;
    longint vx[3];
    longint vy[3];
    longint tx;
    longint ty;
    longint row;
    longint xs;
    longint xe;
    longint sw;
    int j;
    vx[0] = r.first_x;  vy[0] = r.first_y;
    vx[1] = r.second_x; vy[1] = r.second_y;
    vx[2] = r.third_x;  vy[2] = r.third_y;
    row = r.row_y;
    for (int i = 1; i < 3; i++) begin
      tx = vx[i];
      ty = vy[i];
      j = i;
      while (j > 0 && vy[j-1] > ty) begin
        vx[j] = vx[j-1];
        vy[j] = vy[j-1];
        j--;
      end
      vx[j] = tx;
      vy[j] = ty;
    end
    s = '0;
    s.span_row = r.row_y;
    s.span_colour = r.fill_colour;
    s.covered = (row >= vy[0]) && (row <= vy[2]);
    if (s.covered) begin
      if (row < vy[1]) xs = edge_at(vx[0], vy[0], vx[1], vy[1], row);
      else xs = edge_at(vx[1], vy[1], vx[2], vy[2], row);
      xe = edge_at(vx[0], vy[0], vx[2], vy[2], row);
      if (xs > xe) begin
        sw = xs;
        xs = xe;
        xe = sw;
      end
      s.span_start = tssu_pkg::COORD_BITS'(xs);
      s.span_end = tssu_pkg::COORD_BITS'(xe);
    end
    return s;
  endfunction

  function automatic logic signed [tssu_pkg::COORD_BITS-1:0] rand_coord(int mode);
    case (mode)
      0: return tssu_pkg::COORD_BITS'($urandom);
      1: return tssu_pkg::COORD_BITS'($urandom_range(0, 64) - 32);
      default: return tssu_pkg::COORD_BITS'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  function automatic tssu_pkg::req_t rand_req();
    tssu_pkg::req_t r;
    int mode;
    int lo;
    int hi;
    mode = $urandom_range(0, 2);
    r.first_x = rand_coord(mode);
    r.first_y = rand_coord(mode);
    r.second_x = rand_coord(mode);
    r.second_y = ($urandom_range(0, 7) == 0) ? r.first_y : rand_coord(mode);
    r.third_x = rand_coord(mode);
    r.third_y = ($urandom_range(0, 7) == 0) ? r.second_y : rand_coord(mode);
    r.fill_colour = $urandom;
    lo = r.first_y;
    hi = r.first_y;
    if (r.second_y < lo) lo = r.second_y;
    if (r.third_y < lo) lo = r.third_y;
    if (r.second_y > hi) hi = r.second_y;
    if (r.third_y > hi) hi = r.third_y;
    if ($urandom_range(0, 9) < 8) begin
      r.row_y = tssu_pkg::COORD_BITS'($urandom_range(lo + 2048, hi + 2048) - 2048);
    end else begin
      r.row_y = tssu_pkg::COORD_BITS'($urandom);
    end
    return r;
  endfunction

  function automatic tssu_pkg::req_t make_req(int ax, int ay, int bx, int by, int cx, int cy,
                                              int row, int colour);
    tssu_pkg::req_t r;
    r.first_x = tssu_pkg::COORD_BITS'(ax);  r.first_y = tssu_pkg::COORD_BITS'(ay);
    r.second_x = tssu_pkg::COORD_BITS'(bx); r.second_y = tssu_pkg::COORD_BITS'(by);
    r.third_x = tssu_pkg::COORD_BITS'(cx);  r.third_y = tssu_pkg::COORD_BITS'(cy);
    r.row_y = tssu_pkg::COORD_BITS'(row);
    r.fill_colour = tssu_pkg::COLOUR_BITS'(colour);
    return r;
  endfunction

  task automatic queue_req(tssu_pkg::req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_spans.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (pending_reqs.size() != 0 && !send_pause && $urandom_range(0, 99) >= send_idle_pct)
          begin
        req <= pending_reqs[0];
        expected_spans.insert(expected_spans.size(), predict_span(pending_reqs.pop_front()));
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      span_ready <= 1'b0;
    end else begin
      if (span_valid && span_ready) begin
        spans_seen++;
        if (span.covered) covered_seen++;
        if (expected_spans.size() == 0) begin
          $display("%0t: span with nothing expected, actual %h", $time, span);
          errors++;
        end else begin
          if (span !== expected_spans[0]) begin
            $display("%0t: span mismatch, expected row %0d cov %0b start %0d end %0d col %h",
                     $time, expected_spans[0].span_row, expected_spans[0].covered,
                     expected_spans[0].span_start, expected_spans[0].span_end,
                     expected_spans[0].span_colour);
            $display("%0t:                actual row %0d cov %0b start %0d end %0d col %h",
                     $time, span.span_row, span.covered, span.span_start, span.span_end,
                     span.span_colour);
            errors++;
          end
          void'(expected_spans.pop_front());
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        span_ready <= 1'b0;
      end else begin
        span_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    errors = 0;
    spans_seen = 0;
    covered_seen = 0;
    hold_off_cycles = 0;
    send_pause = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 49;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_req(make_req(0, 0, 10, 10, -10, 20, 5, 24'hFF0000));
    queue_req(make_req(0, 0, 10, 10, -10, 20, 10, 24'h00FF00));
    queue_req(make_req(0, 0, 10, 10, -10, 20, 20, 24'h0000FF));
    queue_req(make_req(0, 0, 10, 10, -10, 20, 21, 24'hFFFFFF));
    queue_req(make_req(0, 0, 10, 10, -10, 20, -1, 24'h000000));
    queue_req(make_req(-2048, -2048, 2047, 2047, -2048, 2047, 0, 24'h123456));
    queue_req(make_req(2047, -2048, -2048, 2047, 2047, 2047, 2047, 24'hABCDEF));
    queue_req(make_req(2047, -2048, -2048, 2047, 2047, 2047, -2048, 24'h654321));
    queue_req(make_req(-2048, 2047, 2047, -2048, 0, 0, 1, 24'h0F0F0F));
    queue_req(make_req(5, 3, -7, 3, 9, 3, 3, 24'hF0F0F0));
    queue_req(make_req(5, 3, -7, 3, 9, 3, 4, 24'h808080));
    queue_req(make_req(1, 0, 3, 0, 2, 9, 0, 24'h7F7F7F));
    queue_req(make_req(1, 0, 3, 9, 2, 9, 9, 24'h010101));
    queue_req(make_req(0, 0, 7, 3, 0, 0, 2, 24'hFEFEFE));
    queue_req(make_req(-3, 0, 0, 7, 4, 3, 1, 24'h55AA55));
    queue_req(make_req(-3, 0, 0, 7, 4, 3, 6, 24'hAA55AA));
    queue_req(make_req(100, 50, -100, -50, 7, 1, 0, 24'h3C3C3C));
    queue_req(make_req(-1, -1, -1, -1, -1, -1, -1, 24'hC3C3C3));
    for (int i = 0; i < 130; i++) queue_req(rand_req());
    wait_drained();

    send_idle_pct = 0;
    hold_off_cycles = 80;
    for (int i = 0; i < 40; i++) queue_req(rand_req());
    wait_drained();

    send_idle_pct = 49;
    recv_idle_pct = 7;
    for (int i = 0; i < 110; i++) queue_req(rand_req());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 120; i++) queue_req(rand_req());
    wait_drained();
    repeat (tssu_pkg::COORD_BITS + 10) @(posedge clk);

    $display("Sent %0d requests over three idling profiles and one long output stall;",
             spans_seen);
    $display("%0d of the returned spans were covered rows.", covered_seen);
    if (errors == 0) begin
      $display("tb_triangle_scanline_span_unit: done, clean");
    end else begin
      $display("tb_triangle_scanline_span_unit: done, errors");
    end
    $finish;
  end
endmodule
